// ----- hdl/mngml_pkg.sv -----
// Shared types and constants for the MIDI note gate mapper with learn mode.
// Used by the top level, the table module and the checker. No dependencies.
package mngml_pkg;

    // Default number of table entries.
    localparam int ENTRIES_DEF = 8;

    // Width of the gate vector shown in a result.
    localparam int GATE_W = 8;

    // Width of the blink slot field in a result.
    localparam int BLINK_W = 3;

    typedef enum logic [1:0] {
        OP_NOTE_ON     = 2'd0,
        OP_NOTE_OFF    = 2'd1,
        OP_LEARN_START = 2'd2,
        OP_LEARN_STOP  = 2'd3
    } op_t;

    // One note event.
    typedef struct packed {
        op_t        opcode;
        logic [3:0] channel;
        logic [6:0] note;
    } ev_t;

    // One result: the state after an event.
    typedef struct packed {
        logic [GATE_W-1:0]  gate_bits;
        logic               learning;
        logic [BLINK_W-1:0] blink_slot;
    } res_t;

endpackage

// ----- hdl/mngml_table.sv -----
// Learned (channel, note) table, gate flags and learn sequencer.
// Depends on mngml_pkg for the event and result types.
module mngml_table #(
    parameter int ENTRIES = mngml_pkg::ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mngml_pkg::ev_t    ev,
    output mngml_pkg::res_t   res
);

    localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PAD_W      = (ENTRIES > mngml_pkg::GATE_W) ? ENTRIES : mngml_pkg::GATE_W;
    localparam int SLOT_PAD_W = (SLOT_W > mngml_pkg::BLINK_W) ? SLOT_W : mngml_pkg::BLINK_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

    logic [3:0]        entry_channel_reg [ENTRIES];
    logic [6:0]        entry_note_reg    [ENTRIES];
    logic [ENTRIES-1:0] entry_valid_reg;
    logic [ENTRIES-1:0] entry_valid_next;
    logic [ENTRIES-1:0] gate_reg;
    logic [ENTRIES-1:0] gate_next;
    logic              learn_active_reg;
    logic              learn_active_next;
    logic [SLOT_W-1:0] learn_slot_reg;
    logic [SLOT_W-1:0] learn_slot_next;

    logic               wr_en;
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] forced;
    logic [ENTRIES-1:0] shown;
    logic [PAD_W-1:0]   shown_pad;
    logic [SLOT_PAD_W-1:0] slot_pad;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = entry_valid_reg[i]
                       && (entry_channel_reg[i] == ev.channel)
                       && (entry_note_reg[i] == ev.note);
        end
    end

    always_comb
    begin
        gate_next         = gate_reg;
        entry_valid_next  = entry_valid_reg;
        learn_active_next = learn_active_reg;
        learn_slot_next   = learn_slot_reg;
        wr_en             = 1'b0;
        case (ev.opcode)
            mngml_pkg::OP_NOTE_ON:
            begin
                if (!learn_active_reg)
                begin
                    gate_next = gate_reg | match;
                end
                else
                begin
                    wr_en = 1'b1;
                    entry_valid_next[learn_slot_reg] = 1'b1;
                    if (learn_slot_reg == LAST_SLOT)
                    begin
                        learn_active_next = 1'b0;
                        learn_slot_next   = '0;
                    end
                    else
                    begin
                        learn_slot_next = learn_slot_reg + SLOT_W'(1);
                    end
                end
            end
            mngml_pkg::OP_NOTE_OFF:
            begin
                if (!learn_active_reg)
                begin
                    gate_next = gate_reg & ~match;
                end
            end
            mngml_pkg::OP_LEARN_START:
            begin
                if (!learn_active_reg)
                begin
                    learn_active_next = 1'b1;
                    learn_slot_next   = '0;
                end
            end
            mngml_pkg::OP_LEARN_STOP:
            begin
                learn_active_next = 1'b0;
                learn_slot_next   = '0;
            end
            default:
            begin
                learn_active_next = learn_active_reg;
            end
        endcase
    end

    // The result reflects the state after this event.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            forced[i] = learn_active_next && (learn_slot_next == SLOT_W'(i));
        end
        shown          = gate_next & ~forced;
        shown_pad      = PAD_W'(shown);
        slot_pad       = SLOT_PAD_W'(learn_slot_next);
        res.gate_bits  = shown_pad[mngml_pkg::GATE_W-1:0];
        res.learning   = learn_active_next;
        res.blink_slot = learn_active_next ? slot_pad[mngml_pkg::BLINK_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg  <= '0;
            gate_reg         <= '0;
            learn_active_reg <= 1'b0;
            learn_slot_reg   <= '0;
        end
        else if (fire)
        begin
            entry_valid_reg  <= entry_valid_next;
            gate_reg         <= gate_next;
            learn_active_reg <= learn_active_next;
            learn_slot_reg   <= learn_slot_next;
        end
    end

    // Pair storage is qualified by the valid bits, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
        begin
            entry_channel_reg[learn_slot_reg] <= ev.channel;
            entry_note_reg[learn_slot_reg]    <= ev.note;
        end
    end

endmodule

// ----- hdl/midi_note_gate_mapper_learn.sv -----
// Top level of the MIDI note gate mapper with learn mode.
// Depends on mngml_pkg and instantiates mngml_table.

// The block takes one note event per transfer on the ev channel and returns
// exactly one result per event on the res channel, showing the gate vector,
// the learn flag and the slot being learned after that event. It sustains
// one event per clock cycle while res_ready keeps the result register
// draining: every table entry is compared in parallel in a single pass
// between the event register and the result register. An event is taken
// into the event register and its result is then registered in the result
// register, from which it is offered on res.
// A result waiting on res_ready does not stop the next event from being
// taken into the event register; only when both registers are full does
// ev_ready drop. While learning, note-ons fill slots from 0 upward and
// note-offs are ignored; for ENTRIES <= GATE_W the learn slot gate is low.
module midi_note_gate_mapper_learn #(
    parameter int ENTRIES = mngml_pkg::ENTRIES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ev_valid,
    output logic            ev_ready,
    input  mngml_pkg::ev_t  ev_data,
    output logic            res_valid,
    input  logic            res_ready,
    output mngml_pkg::res_t res_data
);

    logic            stage_valid_reg;
    logic            stage_valid_next;
    mngml_pkg::ev_t  stage_data_reg;
    logic            res_valid_reg;
    logic            res_valid_next;
    mngml_pkg::res_t res_data_reg;
    mngml_pkg::res_t table_res;
    logic            ev_accept;
    logic            advance;

    // The event register moves on whenever the result register is free or
    // is being emptied in this cycle.
    assign advance   = stage_valid_reg && (!res_valid_reg || res_ready);
    assign ev_ready  = !stage_valid_reg || advance;
    assign ev_accept = ev_valid && ev_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (ev_accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // The table commits its state update in the same cycle that the result
    // is captured, so events are applied strictly in arrival order.
    mngml_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .ev    (stage_data_reg),
        .res   (table_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_accept)
        begin
            stage_data_reg <= ev_data;
        end
        if (advance)
        begin
            res_data_reg <= table_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ----- hdl/mngml_checker.sv -----
// Port-level checks for the MIDI note gate mapper, bound to the top level.
// Depends on mngml_pkg and on midi_note_gate_mapper_learn.
module mngml_checker #(
    parameter int ENTRIES = mngml_pkg::ENTRIES_DEF
) (
    input logic            clk,
    input logic            rst_n,
    input logic            ev_valid,
    input logic            ev_ready,
    input logic            res_valid,
    input logic            res_ready,
    input mngml_pkg::res_t res_data
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
    else $error("result transfer dropped before it was taken");

    // With the result register empty, the block must be able to take an event.
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> ev_ready)
    else $error("event refused while no result is pending");

    // A fresh result is preceded by a matching event transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(ev_valid && ev_ready, 2))
    else $error("result appeared without a matching event transfer");

    // Outside learning the blink slot reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.learning) |-> (res_data.blink_slot == '0))
    else $error("blink slot set while not learning");

    // The slot being learned shows its gate low when ENTRIES <= GATE_W.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.learning && (ENTRIES <= mngml_pkg::GATE_W))
        |-> !res_data.gate_bits[res_data.blink_slot])
    else $error("gate of the slot under learning is not forced low");

endmodule

bind midi_note_gate_mapper_learn mngml_checker #(
    .ENTRIES (ENTRIES)
) u_mngml_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (ev_valid),
    .ev_ready  (ev_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);
